// ===== rtl/bpcd_pkg.sv =====
// Types, codes and helpers shared by the beacon pulse-code decoder.
`timescale 1ns / 1ps

package bpcd_pkg;

  localparam int TIME_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int PHASE_W       = 3;
  localparam int ID_W          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AVG_PERIOD   = 3'd0,
    CFG_TOLERANCE    = 3'd1,
    CFG_MIN_HIGH     = 3'd2,
    CFG_MIN_LOW_GAP  = 3'd3,
    CFG_RESYNC_GAP   = 3'd4,
    CFG_INVERT_LEVEL = 3'd5
  } cfg_idx_t;

  typedef enum logic [7:0] {
    PH_WAIT  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_ID0   = 8'b0000_0100,
    PH_GAP   = 8'b0000_1000,
    PH_ID1   = 8'b0001_0000,
    PH_ID2   = 8'b0010_0000,
    PH_ID3   = 8'b0100_0000,
    PH_FAIL  = 8'b1000_0000
  } phase_t;

  localparam logic [PHASE_W-1:0] PCODE_WAIT  = 3'd0;
  localparam logic [PHASE_W-1:0] PCODE_START = 3'd1;
  localparam logic [PHASE_W-1:0] PCODE_ID0   = 3'd2;
  localparam logic [PHASE_W-1:0] PCODE_GAP   = 3'd3;
  localparam logic [PHASE_W-1:0] PCODE_ID1   = 3'd4;
  localparam logic [PHASE_W-1:0] PCODE_ID2   = 3'd5;
  localparam logic [PHASE_W-1:0] PCODE_ID3   = 3'd6;
  localparam logic [PHASE_W-1:0] PCODE_FAIL  = 3'd7;

  localparam logic [ID_W-1:0] BEACON_0 = 2'd0;
  localparam logic [ID_W-1:0] BEACON_1 = 2'd1;
  localparam logic [ID_W-1:0] BEACON_2 = 2'd2;
  localparam logic [ID_W-1:0] BEACON_3 = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] edge_time;
    logic               pin_level;
    logic [FIELD_W-1:0] rotation_stamp;
    logic [FIELD_W-1:0] rotation_prev_stamp;
  } in_word_t;

  typedef struct packed {
    logic               beacon_found;
    logic [ID_W-1:0]    beacon_id;
    logic [FIELD_W-1:0] beacon_start_time;
    logic [FIELD_W-1:0] rotation_at_beacon;
    logic [FIELD_W-1:0] rotation_prev_at_beacon;
    logic [FIELD_W-1:0] frame_rotation;
    logic [FIELD_W-1:0] old_frame_rotation;
    logic [PHASE_W-1:0] phase_out;
  } out_word_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] c;
    unique case (ph)
      PH_WAIT:  c = PCODE_WAIT;
      PH_START: c = PCODE_START;
      PH_ID0:   c = PCODE_ID0;
      PH_GAP:   c = PCODE_GAP;
      PH_ID1:   c = PCODE_ID1;
      PH_ID2:   c = PCODE_ID2;
      PH_ID3:   c = PCODE_ID3;
      PH_FAIL:  c = PCODE_FAIL;
      default:  c = PCODE_FAIL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/beacon_pulse_code_decoder.sv =====
// Beacon pulse-code decoder: edge interval classifier and frame latch, top level.
// An accepted word is held in the input register; its result word is then held in the result register.
// Throughput: one edge word per cycle unless out_ready stalls the result register; the phase update
// is a single registered pass between the input register and the result register.
// Reset (rst_n low, synchronous): phase to wait, all held times and stamps and
// every configuration register to zero, both word registers empty.
`timescale 1ns / 1ps

module beacon_pulse_code_decoder
  import bpcd_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int TB    = TIME_BITS;
  localparam int CMP_W = (TB > 18) ? TB : 18;
  localparam int EXT_W = 32;

  // configuration
  logic [CFG_DATA_W-1:0] avg_r, tol_r, min_high_r, min_low_gap_r, resync_r;
  logic                  invert_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r         <= '0;
      tol_r         <= '0;
      min_high_r    <= '0;
      min_low_gap_r <= '0;
      resync_r      <= '0;
      invert_r      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVG_PERIOD:   avg_r         <= cfg_data;
        CFG_TOLERANCE:    tol_r         <= cfg_data;
        CFG_MIN_HIGH:     min_high_r    <= cfg_data;
        CFG_MIN_LOW_GAP:  min_low_gap_r <= cfg_data;
        CFG_RESYNC_GAP:   resync_r      <= cfg_data;
        CFG_INVERT_LEVEL: invert_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  in_word_t s1_r;
  logic     s1_valid_r;
  logic     advance;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  // decoder state
  phase_t          phase_r, phase_nxt;
  logic [TB-1:0]   prev_r, frame_start_r, last_start_r, held_rot_r, held_rotp_r;
  logic [TB-1:0]   frame_rot_r, old_frame_rot_r;
  logic [TB-1:0]   frame_start_nxt, last_start_nxt, held_rot_nxt, held_rotp_nxt;
  logic [TB-1:0]   frame_rot_nxt, old_frame_rot_nxt;
  logic [ID_W-1:0] found_id_r, found_id_nxt;
  logic            found;

  logic [EXT_W-1:0] now_ext, rot_ext, rotp_ext;
  logic [TB-1:0]    now, rot, rotp, tps;
  logic             high;
  logic [CMP_W-1:0] tps_c, w1, w2, w3, min_high_c, min_low_c, resync_c;
  logic             open_frame, complete;
  logic [ID_W-1:0]  code_id;

  assign now_ext  = EXT_W'(s1_r.edge_time);
  assign rot_ext  = EXT_W'(s1_r.rotation_stamp);
  assign rotp_ext = EXT_W'(s1_r.rotation_prev_stamp);
  assign now      = now_ext[TB-1:0];
  assign rot      = rot_ext[TB-1:0];
  assign rotp     = rotp_ext[TB-1:0];
  assign high     = s1_r.pin_level ^ invert_r;
  assign tps      = now - prev_r;

  assign tps_c      = CMP_W'(tps);
  assign w1         = CMP_W'(avg_r) + CMP_W'(tol_r);
  assign w2         = w1 + CMP_W'(avg_r);
  assign w3         = w2 + CMP_W'(avg_r);
  assign min_high_c = CMP_W'(min_high_r);
  assign min_low_c  = CMP_W'(min_low_gap_r);
  assign resync_c   = CMP_W'(resync_r);

  always_comb begin
    phase_nxt  = PH_FAIL;
    open_frame = 1'b0;
    complete   = 1'b0;
    code_id    = BEACON_0;
    unique case (phase_r)
      PH_WAIT: begin
        if (high) open_frame = 1'b1;
      end
      PH_START: begin
        if (high || tps_c > w3) phase_nxt = PH_FAIL;
        else if (tps_c > w2)    phase_nxt = PH_ID3;
        else if (tps_c > w1)    phase_nxt = PH_ID2;
        else if (tps_c > min_high_c) phase_nxt = PH_ID0;
      end
      PH_ID0: begin
        if (!high) begin
          phase_nxt = PH_FAIL;
        end else if (tps_c > w2) begin
          complete = 1'b1;
          code_id  = BEACON_0;
        end else if (tps_c > min_low_c && tps_c < w1) begin
          phase_nxt = PH_GAP;
        end
      end
      PH_GAP: begin
        if (!high && tps_c > min_high_c && tps_c < w1) phase_nxt = PH_ID1;
      end
      PH_ID1: begin
        if (high && tps_c > min_high_c) begin
          complete = 1'b1;
          code_id  = BEACON_1;
        end
      end
      PH_ID2: begin
        if (high && tps_c > w1) begin
          complete = 1'b1;
          code_id  = BEACON_2;
        end
      end
      PH_ID3: begin
        if (high && tps_c > min_high_c) begin
          complete = 1'b1;
          code_id  = BEACON_3;
        end
      end
      PH_FAIL: begin
        if (high && tps_c > resync_c) open_frame = 1'b1;
      end
      default: phase_nxt = PH_FAIL;
    endcase
  end

  assign found = complete;

  always_comb begin
    found_id_nxt      = found_id_r;
    last_start_nxt    = last_start_r;
    held_rot_nxt      = held_rot_r;
    held_rotp_nxt     = held_rotp_r;
    frame_start_nxt   = frame_start_r;
    frame_rot_nxt     = frame_rot_r;
    old_frame_rot_nxt = old_frame_rot_r;
    if (complete) begin
      found_id_nxt   = code_id;
      last_start_nxt = frame_start_r;
      held_rot_nxt   = rot;
      held_rotp_nxt  = rotp;
    end
    if (complete || open_frame) begin
      frame_start_nxt   = now;
      old_frame_rot_nxt = frame_rot_r;
      frame_rot_nxt     = rot;
    end
  end

  phase_t phase_sel;
  assign phase_sel = (complete || open_frame) ? PH_START : phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_WAIT;
      prev_r          <= '0;
      frame_start_r   <= '0;
      last_start_r    <= '0;
      held_rot_r      <= '0;
      held_rotp_r     <= '0;
      frame_rot_r     <= '0;
      old_frame_rot_r <= '0;
      found_id_r      <= '0;
    end else if (advance) begin
      phase_r         <= phase_sel;
      prev_r          <= now;
      frame_start_r   <= frame_start_nxt;
      last_start_r    <= last_start_nxt;
      held_rot_r      <= held_rot_nxt;
      held_rotp_r     <= held_rotp_nxt;
      frame_rot_r     <= frame_rot_nxt;
      old_frame_rot_r <= old_frame_rot_nxt;
      found_id_r      <= found_id_nxt;
    end
  end

  // result register
  out_word_t out_nxt;
  out_word_t out_r;
  logic      out_valid_r;
  logic [EXT_W-1:0] last_start_ext, held_rot_ext, held_rotp_ext;
  logic [EXT_W-1:0] frame_rot_ext, old_frame_rot_ext;

  assign last_start_ext    = EXT_W'(last_start_nxt);
  assign held_rot_ext      = EXT_W'(held_rot_nxt);
  assign held_rotp_ext     = EXT_W'(held_rotp_nxt);
  assign frame_rot_ext     = EXT_W'(frame_rot_nxt);
  assign old_frame_rot_ext = EXT_W'(old_frame_rot_nxt);

  always_comb begin
    out_nxt.beacon_found            = found;
    out_nxt.beacon_id               = found_id_nxt;
    out_nxt.beacon_start_time       = last_start_ext[FIELD_W-1:0];
    out_nxt.rotation_at_beacon      = held_rot_ext[FIELD_W-1:0];
    out_nxt.rotation_prev_at_beacon = held_rotp_ext[FIELD_W-1:0];
    out_nxt.frame_rotation          = frame_rot_ext[FIELD_W-1:0];
    out_nxt.old_frame_rotation      = old_frame_rot_ext[FIELD_W-1:0];
    out_nxt.phase_out               = phase_code(phase_sel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_found_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beacon_found |-> out_data.phase_out == PCODE_START)
    else $error("beacon reported without a new frame opening");

  a_found_latches_start: assert property (@(posedge clk) disable iff (!rst_n)
    advance && complete |=> last_start_r == $past(frame_start_r))
    else $error("frame start not carried into beacon start");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_r))
    else $error("stalled input word lost");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(prev_r))
    else $error("decoder state moved without a word");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !s1_valid_r)
    else $error("word registers not emptied by reset");

endmodule

// ===== dv/beacon_pulse_code_decoder_tb.sv =====
// Self-checking testbench for the beacon pulse-code decoder: directed and random edge traffic.
`timescale 1ns / 1ps

module beacon_pulse_code_decoder_tb
  import bpcd_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT = 100000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_AVG_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies
  logic [15:0] avg_cfg = '0, tol_cfg = '0, min_high_cfg = '0, min_low_cfg = '0;
  logic [15:0] resync_cfg = '0;
  logic        inv_cfg = 1'b0;

  // decoder state as predicted
  logic [PHASE_W-1:0] phase_q = PCODE_WAIT;
  logic [15:0]        prev_edge_q = '0, frame_start_q = '0, last_start_q = '0;
  logic [15:0]        held_rot_q = '0, held_rotp_q = '0;
  logic [15:0]        frame_rot_q = '0, old_frame_rot_q = '0;
  logic [ID_W-1:0]    found_id_q = BEACON_0;

  out_word_t   pending_results[$];
  logic [15:0] edge_clock = '0;
  int unsigned edges_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_req = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  beacon_pulse_code_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch on result word %0d, %s: got %h, want %h", words_checked, field,
             got, want);
    mismatches++;
  endtask

  task automatic open_frame(input in_word_t w);
    phase_q         = PCODE_START;
    frame_start_q   = w.edge_time;
    old_frame_rot_q = frame_rot_q;
    frame_rot_q     = w.rotation_stamp;
  endtask

  task automatic close_code(input logic [ID_W-1:0] id, input in_word_t w);
    found_id_q   = id;
    last_start_q = frame_start_q;
    held_rot_q   = w.rotation_stamp;
    held_rotp_q  = w.rotation_prev_stamp;
    open_frame(w);
  endtask

  task automatic decode_edge(input in_word_t w);
    logic        rising;
    logic [15:0] diff;
    logic [17:0] span, mh, ml, rs;
    logic [17:0] w1, w2, w3;
    logic        hit;
    out_word_t   res;
    rising = w.pin_level ^ inv_cfg;
    diff   = w.edge_time - prev_edge_q;
    span   = 18'(diff);
    mh     = 18'(min_high_cfg);
    ml     = 18'(min_low_cfg);
    rs     = 18'(resync_cfg);
    // windows held at 18 bits so they never wrap
    w1  = 18'(avg_cfg) + 18'(tol_cfg);
    w2  = 18'(avg_cfg) * 18'd2 + 18'(tol_cfg);
    w3  = 18'(avg_cfg) * 18'd3 + 18'(tol_cfg);
    hit = 1'b0;
    case (phase_q)
      PCODE_WAIT: begin
        if (rising) open_frame(w);
        else phase_q = PCODE_FAIL;
      end
      PCODE_START: begin
        if (rising || span > w3) phase_q = PCODE_FAIL;
        else if (span > w2) phase_q = PCODE_ID3;
        else if (span > w1) phase_q = PCODE_ID2;
        else if (span > mh) phase_q = PCODE_ID0;
        else phase_q = PCODE_FAIL;
      end
      PCODE_ID0: begin
        if (!rising) phase_q = PCODE_FAIL;
        else if (span > w2) begin
          close_code(BEACON_0, w);
          hit = 1'b1;
        end else if (span > ml && span < w1) phase_q = PCODE_GAP;
        else phase_q = PCODE_FAIL;
      end
      PCODE_GAP: begin
        if (!rising && span > mh && span < w1) phase_q = PCODE_ID1;
        else phase_q = PCODE_FAIL;
      end
      PCODE_ID1: begin
        if (rising && span > mh) begin
          close_code(BEACON_1, w);
          hit = 1'b1;
        end else phase_q = PCODE_FAIL;
      end
      PCODE_ID2: begin
        if (rising && span > w1) begin
          close_code(BEACON_2, w);
          hit = 1'b1;
        end else phase_q = PCODE_FAIL;
      end
      PCODE_ID3: begin
        if (rising && span > mh) begin
          close_code(BEACON_3, w);
          hit = 1'b1;
        end else phase_q = PCODE_FAIL;
      end
      default: begin
        if (rising && span > rs) open_frame(w);
        else phase_q = PCODE_FAIL;
      end
    endcase
    prev_edge_q = w.edge_time;

    res.beacon_found            = hit;
    res.beacon_id               = found_id_q;
    res.beacon_start_time       = last_start_q;
    res.rotation_at_beacon      = held_rot_q;
    res.rotation_prev_at_beacon = held_rotp_q;
    res.frame_rotation          = frame_rot_q;
    res.old_frame_rotation      = old_frame_rot_q;
    res.phase_out               = phase_q;
    pending_results.push_back(res);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("word with nothing pending", 16'(got.phase_out), 16'h0);
      return;
    end
    want = pending_results.pop_front();
    if (got.beacon_found !== want.beacon_found)
      report_mismatch("beacon_found", 16'(got.beacon_found), 16'(want.beacon_found));
    if (got.beacon_id !== want.beacon_id)
      report_mismatch("beacon_id", 16'(got.beacon_id), 16'(want.beacon_id));
    if (got.beacon_start_time !== want.beacon_start_time)
      report_mismatch("beacon_start_time", got.beacon_start_time, want.beacon_start_time);
    if (got.rotation_at_beacon !== want.rotation_at_beacon)
      report_mismatch("rotation_at_beacon", got.rotation_at_beacon,
                      want.rotation_at_beacon);
    if (got.rotation_prev_at_beacon !== want.rotation_prev_at_beacon)
      report_mismatch("rotation_prev_at_beacon", got.rotation_prev_at_beacon,
                      want.rotation_prev_at_beacon);
    if (got.frame_rotation !== want.frame_rotation)
      report_mismatch("frame_rotation", got.frame_rotation, want.frame_rotation);
    if (got.old_frame_rotation !== want.old_frame_rotation)
      report_mismatch("old_frame_rotation", got.old_frame_rotation,
                      want.old_frame_rotation);
    if (got.phase_out !== want.phase_out)
      report_mismatch("phase_out", 16'(got.phase_out), 16'(want.phase_out));
    words_checked++;
  endtask

  // result sink with random and requested stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (stall_req != 0) begin
        stall_left = stall_req;
        stall_req  = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99, 0) >= 10);
      end
    end
  end

  task automatic send_edge(input in_word_t w);
    int unsigned gap;
    gap = 0;
    if (!steady)
      while ($urandom_range(99, 0) < 10) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_edge(w);
    edges_sent++;
  endtask

  // level is the decoded level; the pin is driven through the current inversion
  task automatic send_level(input int unsigned dt, input logic level);
    in_word_t w;
    edge_clock            = edge_clock + 16'(dt);
    w.edge_time           = edge_clock;
    w.pin_level           = level ^ inv_cfg;
    w.rotation_stamp      = 16'($urandom);
    w.rotation_prev_stamp = 16'($urandom);
    send_edge(w);
  endtask

  task automatic await_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] avg, input logic [15:0] tol,
                              input logic [15:0] minh, input logic [15:0] minl,
                              input logic [15:0] res, input logic inv);
    logic [15:0] vals [6];
    cfg_idx_t    idx;
    vals = '{avg, tol, minh, minl, res, {15'd0, inv}};
    await_idle();
    for (int i = 0; i < 6; i++) begin
      idx = cfg_idx_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        CFG_AVG_PERIOD:   avg_cfg      = vals[i];
        CFG_TOLERANCE:    tol_cfg      = vals[i];
        CFG_MIN_HIGH:     min_high_cfg = vals[i];
        CFG_MIN_LOW_GAP:  min_low_cfg  = vals[i];
        CFG_RESYNC_GAP:   resync_cfg   = vals[i];
        CFG_INVERT_LEVEL: inv_cfg      = vals[i][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic program_random();
    int unsigned a;
    a = $urandom_range(3000, 50);
    program_regs(16'(a), 16'($urandom_range(a / 2, 0)), 16'($urandom_range(a / 2, 0)),
                 16'($urandom_range(a / 2, 0)), 16'($urandom_range(4 * a, a)),
                 1'($urandom));
  endtask

  // bring the decoder to the frame start phase
  task automatic sync_frame();
    int tries;
    tries = 0;
    while (phase_q != PCODE_START && tries < 8) begin
      if (phase_q == PCODE_FAIL || phase_q == PCODE_WAIT)
        send_level($urandom_range(32'(resync_cfg) + 32'(avg_cfg), 32'(resync_cfg) + 1),
                   1'b1);
      else
        send_level($urandom_range(32'(avg_cfg), 1), 1'b0);
      tries++;
    end
  endtask

  task automatic send_frame(input logic [ID_W-1:0] id);
    int unsigned a, m, l, w1, w2, w3;
    a  = 32'(avg_cfg);
    m  = 32'(min_high_cfg);
    l  = 32'(min_low_cfg);
    w1 = a + 32'(tol_cfg);
    w2 = 2 * a + 32'(tol_cfg);
    w3 = 3 * a + 32'(tol_cfg);
    case (id)
      BEACON_0: begin
        send_level($urandom_range(w1, m + 1), 1'b0);
        send_level($urandom_range(w2 + a, w2 + 1), 1'b1);
      end
      BEACON_1: begin
        send_level($urandom_range(w1, m + 1), 1'b0);
        send_level($urandom_range(w1 - 1, l + 1), 1'b1);
        send_level($urandom_range(w1 - 1, m + 1), 1'b0);
        send_level($urandom_range(m + a, m + 1), 1'b1);
      end
      BEACON_2: begin
        send_level($urandom_range(w2, w1 + 1), 1'b0);
        send_level($urandom_range(w1 + a, w1 + 1), 1'b1);
      end
      default: begin
        send_level($urandom_range(w3, w2 + 1), 1'b0);
        send_level($urandom_range(m + a, m + 1), 1'b1);
      end
    endcase
  endtask

  task automatic send_noise();
    if ($urandom_range(1, 0) == 1)
      send_level($urandom_range(65535, 0), 1'($urandom));
    else
      send_level($urandom_range(3 * 32'(avg_cfg) + 32'(tol_cfg) + 2, 0), 1'($urandom));
  endtask

  // mostly well-formed frames, some noise that breaks them
  task automatic run_traffic(input int unsigned n_edges);
    int unsigned stop_at;
    stop_at = edges_sent + n_edges;
    while (edges_sent < stop_at) begin
      if ($urandom_range(99, 0) < 80) begin
        sync_frame();
        send_frame(2'($urandom));
      end else begin
        repeat ($urandom_range(3, 1)) send_noise();
      end
    end
  endtask

  task automatic test_reset_and_resync();
    program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_level(65535, 1'b0);    // falling while waiting
    send_level(1, 1'b0);        // timer wraps to zero, falling keeps fail
    send_level(0, 1'b1);        // rising but gap not over resync
    send_level(1, 1'b1);
    send_level(0, 1'b0);        // pulse no longer than min_high
  endtask

  task automatic test_wide_windows();
    program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 1'b1);
    send_level(1, 1'b1);
    send_level(65535, 1'b0);    // far below the 18-bit windows
    send_level(65534, 1'b1);
    send_level(65535, 1'b0);
    send_level(1, 1'b1);        // beacon 1
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_level(9, 1'b1);        // rising at frame start
    send_level(65535, 1'b1);    // resync gap can never be exceeded
  endtask

  task automatic test_window_bounds();
    // windows at 120, 220 and 320
    program_regs(16'd100, 16'd20, 16'd30, 16'd40, 16'd500, 1'b0);
    send_level(501, 1'b1);
    send_level(120, 1'b0);
    send_level(221, 1'b1);
    send_level(220, 1'b0);
    send_level(121, 1'b1);
    send_level(320, 1'b0);
    send_level(31, 1'b1);
    send_level(31, 1'b0);
    send_level(41, 1'b1);
    send_level(119, 1'b0);
    send_level(31, 1'b1);
    send_level(321, 1'b0);      // pulse beyond the widest window
    send_level(500, 1'b1);
    send_level(501, 1'b1);
    send_level(50, 1'b0);
    send_level(40, 1'b1);       // gap equal to min_low_gap
  endtask

  task automatic test_random_traffic();
    program_random();
    run_traffic(90);
  endtask

  task automatic test_back_to_back();
    program_random();
    steady = 1'b1;
    run_traffic(60);
    steady = 1'b0;
  endtask

  task automatic test_output_stall();
    program_random();
    stall_req = 300;
    run_traffic(40);
  endtask

  task automatic test_mid_frame_pause();
    program_random();
    repeat (5) begin
      sync_frame();
      send_level($urandom_range(32'(avg_cfg) + 32'(tol_cfg), 32'(min_high_cfg) + 1), 1'b0);
      await_idle();
      send_level($urandom_range(3 * 32'(avg_cfg) + 32'(tol_cfg),
                                2 * 32'(avg_cfg) + 32'(tol_cfg) + 1), 1'b1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_resync();
    test_wide_windows();
    test_window_bounds();
    repeat (4) test_random_traffic();
    test_back_to_back();
    test_output_stall();
    test_mid_frame_pause();
    await_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpcd_pkg.sv
rtl/beacon_pulse_code_decoder.sv
dv/beacon_pulse_code_decoder_tb.sv
